// ===== rtl/ldr_pkg.sv =====
// Shared constants and types for the lens distortion remap address generator.
package ldr_pkg;

	// Source frame defaults
	localparam int SRC_ROWS_DEF = 512;
	localparam int SRC_COLS_DEF = 640;

	// Field and register widths
	localparam int POS_W    = 10;   // out_row / out_col
	localparam int DIM_W    = 11;   // out_width / out_height
	localparam int COEF_W   = 32;   // radial coefficients
	localparam int ASP_W    = 31;   // y_aspect, Q.30
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Datapath widths
	localparam int YM_W   = 41;     // |yc * y_aspect|
	localparam int R2_W   = 55;     // r2, Q.32
	localparam int R4_W   = 62;     // r4, Q.16
	localparam int T2_W   = 48;     // coef*r2 term after >>40
	localparam int T4_W   = 54;     // coef*r4 term after >>40
	localparam int NUM_W  = 56;     // num / den, signed Q.32
	localparam int MAG_W  = 55;     // |num| / |den|
	localparam int DIV_W  = 97;     // dividend / divisor of the rounding divide
	localparam int QUO_W  = 11;     // rounded quotient bits kept before overflow

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_WIDTH  = 3'd0,
		CFG_OUT_HEIGHT = 3'd1,
		CFG_NUM_R2     = 3'd2,
		CFG_NUM_R4     = 3'd3,
		CFG_DEN_R2     = 3'd4,
		CFG_DEN_R4     = 3'd5,
		CFG_Y_ASPECT   = 3'd6
	} cfg_idx_t;

	// Register reset values
	localparam logic [DIM_W-1:0]         RST_OUT_WIDTH  = 11'd938;
	localparam logic [DIM_W-1:0]         RST_OUT_HEIGHT = 11'd606;
	localparam logic signed [COEF_W-1:0] RST_NUM_R2     = 32'sd13354255;
	localparam logic signed [COEF_W-1:0] RST_NUM_R4     = 32'sd1414;
	localparam logic signed [COEF_W-1:0] RST_DEN_R2     = 32'sd18165792;
	localparam logic signed [COEF_W-1:0] RST_DEN_R4     = 32'sd1107618;
	localparam logic [ASP_W-1:0]         RST_Y_ASPECT   = 31'd1061856250;

endpackage

// ===== rtl/ldr_if.sv =====
// Valid/ready channel interfaces for pixel positions and remap results.
interface ldr_pix_if;
	logic                        valid;
	logic                        ready;
	logic [ldr_pkg::POS_W-1:0]   out_row;
	logic [ldr_pkg::POS_W-1:0]   out_col;

	modport source (output valid, output out_row, output out_col, input ready);
	modport sink (input valid, input out_row, input out_col, output ready);
endinterface

interface ldr_map_if #(
	parameter int ROW_W = $clog2(ldr_pkg::SRC_ROWS_DEF),
	parameter int COL_W = $clog2(ldr_pkg::SRC_COLS_DEF)
);
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] src_row;
	logic [COL_W-1:0] src_col;
	logic             inside_res;

	modport source (output valid, output src_row, output src_col, output inside_res,
		input ready);
	modport sink (input valid, input src_row, input src_col, input inside_res,
		output ready);
endinterface

// ===== rtl/ldr_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage plus an overflow flag.
module ldr_divider #(
	parameter int NW = ldr_pkg::DIV_W,
	parameter int QW = ldr_pkg::QUO_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic [QW-1:0] quot,
	output logic          over
);

	logic [NW-1:0] rem_s [QW];
	logic [NW-1:0] dvs_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic          ovf_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [NW-1:0] rin;
		logic [NW-1:0] din;
		logic [NW-1:0] sub;
		logic [QW-1:0] qin;
		logic          oin;
		logic          take;

		if (g == 0) begin : g_first
			// quotient of more than QW bits can never land in frame
			assign rin = dividend;
			assign din = divisor;
			assign qin = '0;
			assign oin = dividend >= (divisor << QW);
		end else begin : g_next
			assign rin = rem_s[g-1];
			assign din = dvs_s[g-1];
			assign qin = quo_s[g-1];
			assign oin = ovf_s[g-1];
		end

		// trial subtract of the shifted divisor
		assign sub  = din << (QW - 1 - g);
		assign take = rin >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= take ? rin - sub : rin;
				dvs_s[g] <= din;
				quo_s[g] <= qin | (take ? ({{(QW-1){1'b0}}, 1'b1} << (QW - 1 - g)) : '0);
				ovf_s[g] <= oin;
			end
		end
	end

	assign quot = quo_s[QW-1];
	assign over = ovf_s[QW-1];

endmodule

// ===== rtl/lens_distortion_remap.sv =====
// Top level: rational radial lens distortion remap address generator.
//
//  port       dir  payload                           transfer when
//  pixel      in   out_row, out_col                  pixel.valid & pixel.ready
//  remap      out  src_row, src_col, inside_res      remap.valid & remap.ready
//  cfg_*      in   cfg_index, cfg_data               cfg_wr_en
//
// One pixel per clock while the output is not stalled; the pipe is 12 + QUO_W stages up to the output register.
// The 11 multiply/add stages and the QUO_W-stage restoring divider set the depth.
// arst_n clears all valid bits and loads register defaults; payload is not reset.
// The whole pipe advances when the output register is empty or being taken;
// a stall freezes every stage in place and holds pixel.ready low.
module lens_distortion_remap #(
	parameter int SRC_ROWS = ldr_pkg::SRC_ROWS_DEF,
	parameter int SRC_COLS = ldr_pkg::SRC_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ldr_pix_if.sink                       pixel,
	ldr_map_if.source                     remap,
	input  logic                          cfg_wr_en,
	input  logic [ldr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ldr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_W = $clog2(SRC_ROWS);
	localparam int COL_W = $clog2(SRC_COLS);
	localparam int QW    = ldr_pkg::QUO_W;
	localparam int NW    = ldr_pkg::DIV_W;
	localparam int CW    = QW + 2;  // signed width for final address math

	localparam logic signed [CW-1:0] ROW_HALF = CW'(SRC_ROWS / 2);
	localparam logic signed [CW-1:0] COL_HALF = CW'(SRC_COLS / 2);
	localparam logic signed [CW-1:0] ROW_LIM  = CW'(SRC_ROWS);
	localparam logic signed [CW-1:0] COL_LIM  = CW'(SRC_COLS);

	localparam logic signed [87:0] BIAS2 = 88'sh00_0000_00FF_FFFF_FFFF;
	localparam logic signed [93:0] BIAS4 = 94'sh000_0000_00FF_FFFF_FFFF;
	localparam logic signed [ldr_pkg::NUM_W-1:0] NUM_ONE = 56'sh00_0001_0000_0000;

	// ---------------------------------------------------------------
	// Configuration registers
	logic [ldr_pkg::DIM_W-1:0]         width_q, height_q;
	logic signed [ldr_pkg::COEF_W-1:0] num_r2_q, num_r4_q, den_r2_q, den_r4_q;
	logic [ldr_pkg::ASP_W-1:0]         aspect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ldr_pkg::RST_OUT_WIDTH;
			height_q <= ldr_pkg::RST_OUT_HEIGHT;
			num_r2_q <= ldr_pkg::RST_NUM_R2;
			num_r4_q <= ldr_pkg::RST_NUM_R4;
			den_r2_q <= ldr_pkg::RST_DEN_R2;
			den_r4_q <= ldr_pkg::RST_DEN_R4;
			aspect_q <= ldr_pkg::RST_Y_ASPECT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ldr_pkg::CFG_OUT_WIDTH:  width_q  <= cfg_data[ldr_pkg::DIM_W-1:0];
				ldr_pkg::CFG_OUT_HEIGHT: height_q <= cfg_data[ldr_pkg::DIM_W-1:0];
				ldr_pkg::CFG_NUM_R2:     num_r2_q <= cfg_data;
				ldr_pkg::CFG_NUM_R4:     num_r4_q <= cfg_data;
				ldr_pkg::CFG_DEN_R2:     den_r2_q <= cfg_data;
				ldr_pkg::CFG_DEN_R4:     den_r4_q <= cfg_data;
				ldr_pkg::CFG_Y_ASPECT:   aspect_q <= cfg_data[ldr_pkg::ASP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Global advance
	logic out_valid_q;
	logic adv;

	assign adv         = !out_valid_q || remap.ready;
	assign pixel.ready = adv;

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic dv_s12 [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5  <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			for (int k = 0; k < QW; k++) dv_s12[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= pixel.valid;
			v_s2  <= v_s1;  v_s3 <= v_s2;  v_s4 <= v_s3;  v_s5 <= v_s4;
			v_s6  <= v_s5;  v_s7 <= v_s6;  v_s8 <= v_s7;  v_s9 <= v_s8;
			v_s10 <= v_s9;  v_s11 <= v_s10;
			dv_s12[0] <= v_s11;
			for (int k = 1; k < QW; k++) dv_s12[k] <= dv_s12[k-1];
			out_valid_q <= dv_s12[QW-1];
		end
	end

	// ---------------------------------------------------------------
	// S1: center the position, split into magnitude and sign
	logic signed [11:0] xc_c, yc_c, xa_c, ya_c;
	logic [9:0] xm_s1, ym_s1;
	logic       xneg_s1, yneg_s1;

	assign xc_c = $signed({2'b00, pixel.out_col}) - $signed({2'b00, width_q[10:1]});
	assign yc_c = $signed({2'b00, height_q[10:1]}) - $signed({2'b00, pixel.out_row});
	assign xa_c = xc_c[11] ? -xc_c : xc_c;
	assign ya_c = yc_c[11] ? -yc_c : yc_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			xm_s1   <= xa_c[9:0];
			ym_s1   <= ya_c[9:0];
			xneg_s1 <= xc_c[11];
			yneg_s1 <= yc_c[11];
		end
	end

	// S2: x squared, y scaled by aspect
	logic [19:0]               xsq_s2;
	logic [ldr_pkg::YM_W-1:0]  y1m_s2;
	logic [9:0]                xm_s2;
	logic                      xneg_s2, yneg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			xsq_s2  <= xm_s1 * xm_s1;
			y1m_s2  <= ym_s1 * aspect_q;
			xm_s2   <= xm_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
		end
	end

	// S3: partial products of y1 squared
	logic [39:0] pyh_s3;
	logic [40:0] pym_s3;
	logic [41:0] pyl_s3;
	logic [19:0] xsq_s3;
	logic [ldr_pkg::YM_W-1:0] y1m_s3;
	logic [9:0]  xm_s3;
	logic        xneg_s3, yneg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pyh_s3  <= y1m_s2[40:21] * y1m_s2[40:21];
			pym_s3  <= y1m_s2[40:21] * y1m_s2[20:0];
			pyl_s3  <= y1m_s2[20:0] * y1m_s2[20:0];
			xsq_s3  <= xsq_s2;
			y1m_s3  <= y1m_s2;
			xm_s3   <= xm_s2;
			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;
		end
	end

	// S4: r2 = x^2 in Q.32 plus trunc(y1^2 / 2^28)
	logic [81:0]                ysq_c;
	logic [ldr_pkg::R2_W-1:0]   r2_s4;
	logic [ldr_pkg::YM_W-1:0]   y1m_s4;
	logic [9:0]                 xm_s4;
	logic                       xneg_s4, yneg_s4;

	assign ysq_c = (82'(pyh_s3) << 42) + (82'(pym_s3) << 22) + 82'(pyl_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s4   <= (55'(xsq_s3) << 32) + 55'(ysq_c >> 28);
			y1m_s4  <= y1m_s3;
			xm_s4   <= xm_s3;
			xneg_s4 <= xneg_s3;
			yneg_s4 <= yneg_s3;
		end
	end

	// S5: partial products of r2^2 and of the r2 coefficient terms
	logic [53:0]        qhh_s5;
	logic [54:0]        qhl_s5;
	logic [55:0]        qll_s5;
	logic signed [58:0] an2h_s5, ad2h_s5;
	logic signed [59:0] an2l_s5, ad2l_s5;
	logic [ldr_pkg::YM_W-1:0] y1m_s5;
	logic [9:0]         xm_s5;
	logic               xneg_s5, yneg_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			qhh_s5  <= r2_s4[54:28] * r2_s4[54:28];
			qhl_s5  <= r2_s4[54:28] * r2_s4[27:0];
			qll_s5  <= r2_s4[27:0] * r2_s4[27:0];
			an2h_s5 <= num_r2_q * $signed({1'b0, r2_s4[54:28]});
			an2l_s5 <= num_r2_q * $signed({1'b0, r2_s4[27:0]});
			ad2h_s5 <= den_r2_q * $signed({1'b0, r2_s4[54:28]});
			ad2l_s5 <= den_r2_q * $signed({1'b0, r2_s4[27:0]});
			y1m_s5  <= y1m_s4;
			xm_s5   <= xm_s4;
			xneg_s5 <= xneg_s4;
			yneg_s5 <= yneg_s4;
		end
	end

	// S6: r4 and the r2 terms, truncated toward zero
	logic [109:0]       r2sq_c;
	logic signed [87:0] sn2_c, sd2_c, tn2_c, td2_c;
	logic [ldr_pkg::R4_W-1:0]        r4_s6;
	logic signed [ldr_pkg::T2_W-1:0] tn2_s6, td2_s6;
	logic [ldr_pkg::YM_W-1:0] y1m_s6;
	logic [9:0]         xm_s6;
	logic               xneg_s6, yneg_s6;

	assign r2sq_c = (110'(qhh_s5) << 56) + (110'(qhl_s5) << 29) + 110'(qll_s5);
	assign sn2_c  = (88'(an2h_s5) <<< 28) + 88'(an2l_s5);
	assign sd2_c  = (88'(ad2h_s5) <<< 28) + 88'(ad2l_s5);
	assign tn2_c  = (sn2_c + (sn2_c[87] ? BIAS2 : 88'sd0)) >>> 40;
	assign td2_c  = (sd2_c + (sd2_c[87] ? BIAS2 : 88'sd0)) >>> 40;

	always_ff @(posedge clk) begin
		if (adv) begin
			r4_s6   <= 62'(r2sq_c >> 48);
			tn2_s6  <= tn2_c[ldr_pkg::T2_W-1:0];
			td2_s6  <= td2_c[ldr_pkg::T2_W-1:0];
			y1m_s6  <= y1m_s5;
			xm_s6   <= xm_s5;
			xneg_s6 <= xneg_s5;
			yneg_s6 <= yneg_s5;
		end
	end

	// S7: partial products of the r4 coefficient terms
	logic signed [62:0] an4h_s7, an4l_s7, ad4h_s7, ad4l_s7;
	logic signed [ldr_pkg::T2_W-1:0] tn2_s7, td2_s7;
	logic [ldr_pkg::YM_W-1:0] y1m_s7;
	logic [9:0]         xm_s7;
	logic               xneg_s7, yneg_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			an4h_s7 <= num_r4_q * $signed({1'b0, r4_s6[61:31]});
			an4l_s7 <= num_r4_q * $signed({1'b0, r4_s6[30:0]});
			ad4h_s7 <= den_r4_q * $signed({1'b0, r4_s6[61:31]});
			ad4l_s7 <= den_r4_q * $signed({1'b0, r4_s6[30:0]});
			tn2_s7  <= tn2_s6;
			td2_s7  <= td2_s6;
			y1m_s7  <= y1m_s6;
			xm_s7   <= xm_s6;
			xneg_s7 <= xneg_s6;
			yneg_s7 <= yneg_s6;
		end
	end

	// S8: numerator and denominator
	logic signed [93:0] sn4_c, sd4_c, tn4_c, td4_c;
	logic signed [ldr_pkg::NUM_W-1:0] num_s8, den_s8;
	logic [ldr_pkg::YM_W-1:0] y1m_s8;
	logic [9:0]         xm_s8;
	logic               xneg_s8, yneg_s8;

	assign sn4_c = (94'(an4h_s7) <<< 31) + 94'(an4l_s7);
	assign sd4_c = (94'(ad4h_s7) <<< 31) + 94'(ad4l_s7);
	assign tn4_c = (sn4_c + (sn4_c[93] ? BIAS4 : 94'sd0)) >>> 40;
	assign td4_c = (sd4_c + (sd4_c[93] ? BIAS4 : 94'sd0)) >>> 40;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s8  <= NUM_ONE + 56'(tn2_s7) + 56'($signed(tn4_c[ldr_pkg::T4_W-1:0]));
			den_s8  <= NUM_ONE + 56'(td2_s7) + 56'($signed(td4_c[ldr_pkg::T4_W-1:0]));
			y1m_s8  <= y1m_s7;
			xm_s8   <= xm_s7;
			xneg_s8 <= xneg_s7;
			yneg_s8 <= yneg_s7;
		end
	end

	// S9: magnitudes, quotient signs, zero denominator
	logic signed [ldr_pkg::NUM_W-1:0] numa_c, dena_c;
	logic [ldr_pkg::MAG_W-1:0] numm_s9, denm_s9;
	logic                      dzero_s9, qxneg_s9, qyneg_s9;
	logic [ldr_pkg::YM_W-1:0]  y1m_s9;
	logic [9:0]                xm_s9;

	assign numa_c = num_s8[55] ? -num_s8 : num_s8;
	assign dena_c = den_s8[55] ? -den_s8 : den_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			numm_s9  <= numa_c[ldr_pkg::MAG_W-1:0];
			denm_s9  <= dena_c[ldr_pkg::MAG_W-1:0];
			dzero_s9 <= den_s8 == '0;
			qxneg_s9 <= xneg_s8 ^ num_s8[55] ^ den_s8[55];
			qyneg_s9 <= yneg_s8 ^ num_s8[55] ^ den_s8[55];
			y1m_s9   <= y1m_s8;
			xm_s9    <= xm_s8;
		end
	end

	// S10: products x1*num and y1*num
	logic [64:0] px_s10;
	logic [67:0] pyh_s10;
	logic [68:0] pyl_s10;
	logic [ldr_pkg::MAG_W-1:0] denm_s10;
	logic        dzero_s10, qxneg_s10, qyneg_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s10    <= xm_s9 * numm_s9;
			pyh_s10   <= y1m_s9 * numm_s9[54:28];
			pyl_s10   <= y1m_s9 * numm_s9[27:0];
			denm_s10  <= denm_s9;
			dzero_s10 <= dzero_s9;
			qxneg_s10 <= qxneg_s9;
			qyneg_s10 <= qyneg_s9;
		end
	end

	// S11: rounding divide operands: (P + D*2^29) / (D*2^30)
	logic [NW-1:0] nx_s11, ny_s11, e_s11;
	logic          dzero_s11, qxneg_s11, qyneg_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s11    <= (NW'(px_s10) << 30) + (NW'(denm_s10) << 29);
			ny_s11    <= (NW'(pyh_s10) << 28) + NW'(pyl_s10) + (NW'(denm_s10) << 29);
			e_s11     <= NW'(denm_s10) << 30;
			dzero_s11 <= dzero_s10;
			qxneg_s11 <= qxneg_s10;
			qyneg_s11 <= qyneg_s10;
		end
	end

	// S12..: rounded quotients, one bit per stage
	logic [QW-1:0] mx_c, my_c;
	logic          ovx_c, ovy_c;

	ldr_divider #(.NW(NW), .QW(QW)) u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (nx_s11),
		.divisor  (e_s11),
		.quot     (mx_c),
		.over     (ovx_c)
	);

	ldr_divider #(.NW(NW), .QW(QW)) u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (ny_s11),
		.divisor  (e_s11),
		.quot     (my_c),
		.over     (ovy_c)
	);

	// side data riding alongside the divider
	logic dzero_s12 [QW];
	logic qxneg_s12 [QW];
	logic qyneg_s12 [QW];

	always_ff @(posedge clk) begin
		if (adv) begin
			dzero_s12[0] <= dzero_s11;
			qxneg_s12[0] <= qxneg_s11;
			qyneg_s12[0] <= qyneg_s11;
			for (int k = 1; k < QW; k++) begin
				dzero_s12[k] <= dzero_s12[k-1];
				qxneg_s12[k] <= qxneg_s12[k-1];
				qyneg_s12[k] <= qyneg_s12[k-1];
			end
		end
	end

	// Final: source address and frame check
	logic signed [CW-1:0] rx_c, ry_c, ii_c, jj_c;
	logic                 in_c;
	logic [ROW_W-1:0]     src_row_q;
	logic [COL_W-1:0]     src_col_q;
	logic                 inside_q;

	assign rx_c = qxneg_s12[QW-1] ? -$signed({2'b00, mx_c}) : $signed({2'b00, mx_c});
	assign ry_c = qyneg_s12[QW-1] ? -$signed({2'b00, my_c}) : $signed({2'b00, my_c});
	assign ii_c = ROW_HALF - ry_c;
	assign jj_c = COL_HALF + rx_c;
	assign in_c = !dzero_s12[QW-1] && !ovx_c && !ovy_c
		&& (ii_c >= 0) && (ii_c < ROW_LIM) && (jj_c >= 0) && (jj_c < COL_LIM);

	always_ff @(posedge clk) begin
		if (adv) begin
			src_row_q <= in_c ? ii_c[ROW_W-1:0] : '0;
			src_col_q <= in_c ? jj_c[COL_W-1:0] : '0;
			inside_q  <= in_c;
		end
	end

	assign remap.valid      = out_valid_q;
	assign remap.src_row    = src_row_q;
	assign remap.src_col    = src_col_q;
	assign remap.inside_res = inside_q;

endmodule
